@@ hw/rtl/lcmc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, fixed-point constants and mode codes for the leg contact
// mode classifier. No dependencies.
package lcmc_pkg;

	localparam int FRAC_BITS = 16;
	// Unsigned Q format wide enough to hold 1.0 exactly.
	localparam int PH_W = FRAC_BITS + 1;
	localparam int PHASE_IN_W = FRAC_BITS + 2;
	localparam int RATE_W = FRAC_BITS + 5;

	localparam longint ONE_L = longint'(1) << FRAC_BITS;
	localparam logic [PH_W-1:0] FX_ONE = PH_W'(ONE_L);
	localparam logic [PH_W-1:0] DUTY_LO = PH_W'((6 * ONE_L + 50) / 100);
	localparam logic [PH_W-1:0] DUTY_HI = PH_W'((94 * ONE_L + 50) / 100);
	localparam logic [PH_W-1:0] GRACE_LIMIT = PH_W'((45 * ONE_L + 50) / 100);
	localparam logic [PH_W-1:0] DUTY_RESET = PH_W'(ONE_L / 2);

	// Divider: one quotient bit per step, a few steps per pipeline stage.
	localparam int QUOT_W = PH_W;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

	localparam logic [2:0] MODE_PLANNED_STANCE = 3'd0;
	localparam logic [2:0] MODE_PLANNED_SWING = 3'd1;
	localparam logic [2:0] MODE_HELD = 3'd2;
	localparam logic [2:0] MODE_GRACE = 3'd3;
	localparam logic [2:0] MODE_LOST = 3'd4;
	localparam logic [2:0] MODE_RECOVERY = 3'd5;
	localparam logic [2:0] MODE_DISABLED = 3'd6;

	// Per-item flags that ride along with the divider.
	typedef struct packed {
		logic enabled;
		logic raw;
		logic lost;
		logic held;
		logic planned;
		logic eff;
		logic stopped;
		logic [PH_W-1:0] phase;
	} lcmc_side_t;

endpackage

@@ hw/rtl/leg_contact_mode_classifier.sv @@
`timescale 1ns / 1ps
// Top level of the leg contact mode classifier: input clamps, mode select
// and output register. Depends on lcmc_pkg and lcmc_divider.
//
// Usage:
// Each item describes one leg. An item is taken at a rising edge with start
// high and busy low; busy is always low, so one item can enter every cycle.
// The result for an item is presented with done high for one cycle, after the
// item has passed the stage 1 register, the divider stages and the output
// register; the edge that ends that cycle accepts the result.
// Results leave in the order the items came in.
// The path is one stage for the clamps and the planned-stance compare, five
// stages of the swing-progress divider (at most four quotient bits per stage), and
// one output register; throughput is one item per cycle.
// The duty factor register is written through cfg_valid/cfg_ready (always
// ready) and should only be changed while no item is in flight.
// Reset clears every valid bit and sets the duty factor to one half; items
// in flight are dropped. The receiver cannot stall, so there is no
// back-pressure anywhere in the pipeline.
module leg_contact_mode_classifier
	import lcmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [PHASE_IN_W-1:0] leg_phase,
	input  logic                  foot_contact,
	input  logic                  fused_lost_candidate,
	input  logic                  hold_stance,
	input  logic                  leg_enable,
	input  logic signed [RATE_W-1:0] stride_rate,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [PH_W-1:0]       cfg_data,
	output logic                  done,
	output logic [2:0]            contact_mode,
	output logic                  stance_kin,
	output logic                  stance_plan,
	output logic                  stance_eff,
	output logic [PH_W-1:0]       swing_progress,
	output logic [PH_W-1:0]       clamped_phase
);

	logic [PH_W-1:0] duty_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= DUTY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			duty_q <= cfg_data;
		end
	end

	// Stage 1: clamps, stance flags and divider operands.
	logic            in_take;
	logic [PH_W-1:0] phase_c;
	logic [PH_W-1:0] duty_c;
	logic            planned_c;
	logic            held_c;
	logic            eff_c;

	assign in_take = start && !busy;

	always_comb begin
		// Below the sign bit the phase has exactly PH_W magnitude bits.
		if (leg_phase[PHASE_IN_W-1]) begin
			phase_c = '0;
		end else if (leg_phase[PH_W-1:0] > FX_ONE) begin
			phase_c = FX_ONE;
		end else begin
			phase_c = leg_phase[PH_W-1:0];
		end

		if (duty_q < DUTY_LO) begin
			duty_c = DUTY_LO;
		end else if (duty_q > DUTY_HI) begin
			duty_c = DUTY_HI;
		end else begin
			duty_c = duty_q;
		end

		planned_c = phase_c < duty_c;
		held_c    = hold_stance && (foot_contact || fused_lost_candidate);
		eff_c     = planned_c || held_c;
	end

	logic            valid_s1;
	logic [PH_W-1:0] diff_s1;
	logic [PH_W-1:0] span_s1;
	lcmc_side_t      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		// A leg in planned stance divides zero; its progress is forced to zero later.
		diff_s1         <= planned_c ? '0 : phase_c - duty_c;
		span_s1         <= FX_ONE - duty_c;
		side_s1.enabled <= leg_enable;
		side_s1.raw     <= foot_contact;
		side_s1.lost    <= fused_lost_candidate;
		side_s1.held    <= held_c;
		side_s1.planned <= planned_c;
		side_s1.eff     <= eff_c;
		side_s1.stopped <= stride_rate[RATE_W-1] || (stride_rate == '0);
		side_s1.phase   <= phase_c;
	end

	logic              div_valid;
	logic [QUOT_W-1:0] div_quot;
	lcmc_side_t        div_side;

	lcmc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_diff   (diff_s1),
		.in_span   (span_s1),
		.in_side   (side_s1),
		.out_valid (div_valid),
		.out_quot  (div_quot),
		.out_side  (div_side)
	);

	// Final stage: progress clamp and mode priority.
	logic [PH_W-1:0] tau_c;
	logic            liftoff_c;
	logic            recovery_c;
	logic [2:0]      mode_c;
	logic            kin_c;

	always_comb begin
		if (div_side.eff) begin
			tau_c = '0;
		end else if (div_quot > FX_ONE) begin
			tau_c = FX_ONE;
		end else begin
			tau_c = div_quot;
		end
		liftoff_c  = !div_side.eff && div_side.raw && (tau_c < GRACE_LIMIT);
		recovery_c = div_side.stopped && !div_side.eff && !div_side.raw && !div_side.lost;

		priority if (!div_side.enabled) begin
			mode_c = MODE_DISABLED;
			kin_c  = 1'b1;
		end else if (div_side.eff && div_side.lost) begin
			mode_c = MODE_LOST;
			kin_c  = 1'b1;
		end else if (div_side.held) begin
			mode_c = MODE_HELD;
			kin_c  = 1'b1;
		end else if (recovery_c) begin
			mode_c = MODE_RECOVERY;
			kin_c  = 1'b0;
		end else if (liftoff_c) begin
			mode_c = MODE_GRACE;
			kin_c  = 1'b0;
		end else if (div_side.planned) begin
			mode_c = MODE_PLANNED_STANCE;
			kin_c  = 1'b1;
		end else begin
			mode_c = MODE_PLANNED_SWING;
			kin_c  = div_side.raw;
		end
	end

	logic            done_q;
	logic [2:0]      mode_q;
	logic            kin_q;
	logic            planned_q;
	logic            eff_q;
	logic [PH_W-1:0] tau_q;
	logic [PH_W-1:0] phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		mode_q    <= mode_c;
		kin_q     <= kin_c;
		planned_q <= div_side.planned;
		eff_q     <= div_side.eff;
		tau_q     <= tau_c;
		phase_q   <= div_side.phase;
	end

	assign done           = done_q;
	assign contact_mode   = mode_q;
	assign stance_kin     = kin_q;
	assign stance_plan    = planned_q;
	assign stance_eff     = eff_q;
	assign swing_progress = tau_q;
	assign clamped_phase  = phase_q;

	// Every result traces back to an item that was registered in stage 1.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1, DIV_STAGES + 1))
		else $error("result without a matching item");

	a_stance_no_progress: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && eff_q |-> tau_q == '0)
		else $error("swing progress nonzero in effective stance");

	a_planned_is_eff: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && planned_q |-> eff_q)
		else $error("planned stance without effective stance");

	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> tau_q <= FX_ONE && phase_q <= FX_ONE)
		else $error("fraction out of range");

	a_grace_only_swing: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (mode_q == MODE_GRACE || mode_q == MODE_RECOVERY) |-> !eff_q && !kin_q)
		else $error("swing-side mode while in stance");

endmodule

@@ hw/rtl/lcmc_divider.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for the normalized swing progress.
// Depends on lcmc_pkg for widths, stage counts and the side-band struct.
module lcmc_divider
	import lcmc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [PH_W-1:0]  in_diff,
	input  logic [PH_W-1:0]  in_span,
	input  lcmc_side_t       in_side,
	output logic             out_valid,
	output logic [QUOT_W-1:0] out_quot,
	output lcmc_side_t       out_side
);

	logic             valid_s [DIV_STAGES];
	logic [PH_W-1:0]  rem_s   [DIV_STAGES];
	logic [PH_W-1:0]  span_s  [DIV_STAGES];
	logic [QUOT_W-1:0] quot_s [DIV_STAGES];
	lcmc_side_t       side_s  [DIV_STAGES];

	// The caller guarantees diff <= span, so the quotient fits in QUOT_W bits
	// and the partial remainder can start as diff itself.
	genvar k;
	for (k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic             valid_in;
		logic [PH_W-1:0]  rem_in;
		logic [PH_W-1:0]  span_in;
		logic [QUOT_W-1:0] quot_in;
		lcmc_side_t       side_in;
		logic [PH_W-1:0]  rem_nx;
		logic [QUOT_W-1:0] quot_nx;

		if (k == 0) begin : g_first
			assign valid_in = in_valid;
			assign rem_in   = in_diff;
			assign span_in  = in_span;
			assign quot_in  = '0;
			assign side_in  = in_side;
		end else begin : g_rest
			assign valid_in = valid_s[k-1];
			assign rem_in   = rem_s[k-1];
			assign span_in  = span_s[k-1];
			assign quot_in  = quot_s[k-1];
			assign side_in  = side_s[k-1];
		end

		always_comb begin
			logic [PH_W-1:0]  r;
			logic [QUOT_W-1:0] q;
			r = rem_in;
			q = quot_in;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (k * DIV_STEPS + j < QUOT_W) begin
					if (r >= span_in) begin
						q = {q[QUOT_W-2:0], 1'b1};
						r = r - span_in;
					end else begin
						q = {q[QUOT_W-2:0], 1'b0};
					end
					// The remainder stays below span, which is below 1.0.
					r = {r[PH_W-2:0], 1'b0};
				end
			end
			rem_nx  = r;
			quot_nx = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_nx;
			span_s[k] <= span_in;
			quot_s[k] <= quot_nx;
			side_s[k] <= side_in;
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_quot  = quot_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

@@ tb/tb_leg_contact_mode_classifier.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for leg_contact_mode_classifier: a queue-fed driver,
// a result monitor and a bit-exact predictor. Depends on lcmc_pkg and the RTL.
module tb_leg_contact_mode_classifier;
	import lcmc_pkg::*;

	localparam longint UNIT = longint'(1) << FRAC_BITS;
	localparam longint DUTY_MIN = (6 * UNIT + 50) / 100;
	localparam longint DUTY_MAX = (94 * UNIT + 50) / 100;
	localparam longint GRACE_Q = (45 * UNIT + 50) / 100;
	localparam int RESULT_LAT = 7;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_SETTING = 82;

	typedef struct {
		logic signed [PHASE_IN_W-1:0] leg_phase;
		logic raw;
		logic lost;
		logic hold;
		logic en;
		logic signed [RATE_W-1:0] stride_rate;
	} leg_item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic kin;
		logic planned;
		logic eff;
		logic [PH_W-1:0] swing;
		logic [PH_W-1:0] phase;
	} leg_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [PHASE_IN_W-1:0] leg_phase = '0;
	logic foot_contact = 1'b0;
	logic fused_lost_candidate = 1'b0;
	logic hold_stance = 1'b0;
	logic leg_enable = 1'b0;
	logic signed [RATE_W-1:0] stride_rate = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PH_W-1:0] cfg_data = '0;
	logic done;
	logic [2:0] contact_mode;
	logic stance_kin;
	logic stance_plan;
	logic stance_eff;
	logic [PH_W-1:0] swing_progress;
	logic [PH_W-1:0] clamped_phase;

	leg_item_t leg_backlog[$];
	leg_result_t pending_verdicts[$];
	logic [PH_W-1:0] duty_backlog[$];

	leg_item_t cur_leg;
	logic [PH_W-1:0] duty_setting = DUTY_RESET;
	int gap_left = 0;
	int burst_left = 0;
	int items_queued = 0;
	int results_seen = 0;
	int duty_writes = 0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	leg_contact_mode_classifier u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.leg_phase(leg_phase),
		.foot_contact(foot_contact),
		.fused_lost_candidate(fused_lost_candidate),
		.hold_stance(hold_stance),
		.leg_enable(leg_enable),
		.stride_rate(stride_rate),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.contact_mode(contact_mode),
		.stance_kin(stance_kin),
		.stance_plan(stance_plan),
		.stance_eff(stance_eff),
		.swing_progress(swing_progress),
		.clamped_phase(clamped_phase)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint clamp_duty(logic [PH_W-1:0] duty_reg);
		longint d;
		d = longint'(duty_reg);
		if (d < DUTY_MIN) d = DUTY_MIN;
		if (d > DUTY_MAX) d = DUTY_MAX;
		return d;
	endfunction

	// Smallest phase whose swing progress reaches the grace limit.
	function automatic longint grace_edge(longint duty_c);
		longint span;
		span = UNIT - duty_c;
		return duty_c + (GRACE_Q * span + UNIT - 1) / UNIT;
	endfunction

	function automatic leg_result_t classify_leg(leg_item_t it, logic [PH_W-1:0] duty_reg);
		leg_result_t r;
		longint ph, duty, tau;
		logic held, stopped, recover, liftoff;
		ph = longint'(it.leg_phase);
		if (ph < 0) ph = 0;
		else if (ph > UNIT) ph = UNIT;
		duty = clamp_duty(duty_reg);
		r.phase = PH_W'(ph);
		r.planned = (ph < duty);
		held = it.hold && (it.raw || it.lost);
		r.eff = r.planned || held;
		stopped = (it.stride_rate <= 0);
		recover = stopped && !r.eff && !it.raw && !it.lost;
		tau = 0;
		if (!r.eff) begin
			tau = ((ph - duty) << FRAC_BITS) / (UNIT - duty);
			if (tau > UNIT) tau = UNIT;
		end
		r.swing = PH_W'(tau);
		liftoff = !r.eff && it.raw && (tau < GRACE_Q);
		if (!it.en) begin
			r.mode = MODE_DISABLED; r.kin = 1'b1;
		end else if (r.eff && it.lost) begin
			r.mode = MODE_LOST; r.kin = 1'b1;
		end else if (held) begin
			r.mode = MODE_HELD; r.kin = 1'b1;
		end else if (recover) begin
			r.mode = MODE_RECOVERY; r.kin = 1'b0;
		end else if (liftoff) begin
			r.mode = MODE_GRACE; r.kin = 1'b0;
		end else if (r.planned) begin
			r.mode = MODE_PLANNED_STANCE; r.kin = 1'b1;
		end else begin
			r.mode = MODE_PLANNED_SWING; r.kin = it.raw;
		end
		return r;
	endfunction

	function automatic leg_item_t random_leg(logic [PH_W-1:0] duty_reg);
		leg_item_t it;
		longint duty;
		int pick;
		duty = clamp_duty(duty_reg);
		pick = $urandom_range(0, 99);
		if (pick < 25)
			it.leg_phase = PHASE_IN_W'($urandom_range(0, (1 << PHASE_IN_W) - 1));
		else if (pick < 60)
			it.leg_phase = PHASE_IN_W'($urandom_range(0, int'(UNIT)));
		else if (pick < 75)
			it.leg_phase = PHASE_IN_W'(duty - 200 + $urandom_range(0, 400));
		else if (pick < 90)
			it.leg_phase = PHASE_IN_W'(grace_edge(duty) - 4 + $urandom_range(0, 8));
		else begin
			case ($urandom_range(0, 7))
				0: it.leg_phase = PHASE_IN_W'(-131072);
				1: it.leg_phase = PHASE_IN_W'(-1);
				2: it.leg_phase = '0;
				3: it.leg_phase = PHASE_IN_W'(1);
				4: it.leg_phase = PHASE_IN_W'(UNIT - 1);
				5: it.leg_phase = PHASE_IN_W'(UNIT);
				6: it.leg_phase = PHASE_IN_W'(UNIT + 1);
				default: it.leg_phase = PHASE_IN_W'(131071);
			endcase
		end
		pick = $urandom_range(0, 99);
		if (pick < 20)
			it.stride_rate = '0;
		else if (pick < 30)
			it.stride_rate = RATE_W'(-int'($urandom_range(1, 655360)));
		else if (pick < 40) begin
			case ($urandom_range(0, 3))
				0: it.stride_rate = RATE_W'(-655360);
				1: it.stride_rate = RATE_W'(-1);
				2: it.stride_rate = RATE_W'(1);
				default: it.stride_rate = RATE_W'(655360);
			endcase
		end else if (pick < 55)
			it.stride_rate = RATE_W'(int'($urandom_range(0, 1310720)) - 655360);
		else
			it.stride_rate = RATE_W'($urandom_range(1, 655360));
		it.raw = 1'($urandom_range(0, 1));
		it.lost = ($urandom_range(0, 99) < 35);
		it.hold = ($urandom_range(0, 99) < 40);
		it.en = ($urandom_range(0, 99) < 88);
		return it;
	endfunction

	task automatic queue_leg(longint ph, logic raw, logic lost, logic hold, logic en,
		longint rate);
		leg_item_t it;
		it.leg_phase = PHASE_IN_W'(ph);
		it.raw = raw;
		it.lost = lost;
		it.hold = hold;
		it.en = en;
		it.stride_rate = RATE_W'(rate);
		leg_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic write_duty(logic [PH_W-1:0] value);
		int target;
		while (results_seen != items_queued) @(negedge clk);
		repeat (RESULT_LAT + 3) @(negedge clk);
		target = duty_writes + 1;
		duty_backlog.push_back(value);
		while (duty_writes != target) @(negedge clk);
	endtask

	// Item driver: one new item per load, with a drawn gap after it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				pending_verdicts.push_back(classify_leg(cur_leg, duty_setting));
			if (!(start && busy)) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (leg_backlog.size() != 0) begin
					cur_leg = leg_backlog.pop_front();
					leg_phase <= cur_leg.leg_phase;
					foot_contact <= cur_leg.raw;
					fused_lost_candidate <= cur_leg.lost;
					hold_stance <= cur_leg.hold;
					leg_enable <= cur_leg.en;
					stride_rate <= cur_leg.stride_rate;
					start <= 1'b1;
					if (burst_left > 0) begin
						gap_left <= 0;
						burst_left <= burst_left - 1;
					end else if ($urandom_range(0, 9) == 0) begin
						gap_left <= 0;
						burst_left <= $urandom_range(8, 30);
					end else begin
						gap_left <= $urandom_range(0, 7);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			duty_setting = cfg_data;
			cfg_valid <= 1'b0;
			duty_writes++;
		end else if (!cfg_valid && duty_backlog.size() != 0) begin
			cfg_data <= duty_backlog.pop_front();
			cfg_valid <= 1'b1;
		end
	end

	always @(posedge clk) begin
		leg_result_t want, got;
		if (arst_n && done) begin
			results_seen++;
			got = '{contact_mode, stance_kin, stance_plan, stance_eff,
				swing_progress, clamped_phase};
			if (pending_verdicts.size() == 0) begin
				if (mismatch_count < 10)
					$display("ERROR: result with nothing expected: mode %0d swing %0d phase %0d",
						got.mode, got.swing, got.phase);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.mode != want.mode || got.kin != want.kin
						|| got.planned != want.planned || got.eff != want.eff
						|| got.swing != want.swing || got.phase != want.phase) begin
					if (mismatch_count < 10)
						$display({"ERROR: mode %0d/%0d kin %0d/%0d planned %0d/%0d ",
							"eff %0d/%0d swing %0d/%0d phase %0d/%0d (expected/actual)"},
							want.mode, got.mode, want.kin, got.kin, want.planned,
							got.planned, want.eff, got.eff, want.swing, got.swing,
							want.phase, got.phase);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which no handshake of any kind completes.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [PH_W-1:0] settings[11];
		longint d;
		settings = '{17'd0, 17'd65536, 17'd3932, 17'd61604, 17'd3931, 17'd61605, 17'd1,
			17'd0, 17'd65535, 17'd0, 17'd32768};
		settings[7] = PH_W'($urandom_range(0, 65536));
		settings[9] = PH_W'($urandom_range(3932, 61604));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items at the reset duty factor of one half.
		d = clamp_duty(DUTY_RESET);
		queue_leg(0, 1, 1, 1, 0, 655360);
		queue_leg(-131072, 0, 0, 0, 0, -655360);
		queue_leg(100, 0, 1, 0, 1, 655360);
		queue_leg(60000, 0, 1, 1, 1, 1);
		queue_leg(60000, 1, 0, 1, 1, 1);
		queue_leg(50000, 0, 0, 0, 1, 0);
		queue_leg(50000, 0, 0, 0, 1, -1);
		queue_leg(50000, 0, 0, 0, 1, 1);
		queue_leg(grace_edge(d) - 1, 1, 0, 0, 1, 1);
		queue_leg(grace_edge(d), 1, 0, 0, 1, 1);
		queue_leg(0, 0, 0, 0, 1, 1);
		queue_leg(d - 1, 0, 0, 0, 1, 1);
		queue_leg(d, 1, 0, 0, 1, 1);
		queue_leg(UNIT, 0, 0, 0, 1, 655360);
		queue_leg(131071, 1, 0, 0, 1, 655360);
		queue_leg(-1, 0, 0, 0, 1, 7);
		queue_leg(UNIT + 1, 1, 0, 0, 1, 0);
		queue_leg(60000, 0, 0, 1, 1, 0);
		queue_leg(60000, 1, 0, 0, 1, -655360);
		queue_leg(60000, 0, 1, 0, 1, 0);
		for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
			leg_backlog.push_back(random_leg(DUTY_RESET));
			items_queued++;
		end

		foreach (settings[s]) begin
			write_duty(settings[s]);
			d = clamp_duty(settings[s]);
			queue_leg(d - 1, 1, 0, 0, 1, 1);
			queue_leg(d, 1, 0, 0, 1, 1);
			queue_leg(grace_edge(d) - 1, 1, 0, 0, 1, 1);
			queue_leg(grace_edge(d), 1, 0, 0, 1, 1);
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				leg_backlog.push_back(random_leg(settings[s]));
				items_queued++;
			end
		end

		while (results_seen != items_queued) @(negedge clk);
		repeat (RESULT_LAT + 3) @(negedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0
				&& results_seen == items_queued)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lcmc_pkg.sv
hw/rtl/lcmc_divider.sv
hw/rtl/leg_contact_mode_classifier.sv
tb/tb_leg_contact_mode_classifier.sv
